// ----- hw/rtl/fdbb_pkg.sv -----
// Shared types and constants for the framebuffer dirty bounding box unit.
`default_nettype none

package fdbb_pkg;

  localparam int CFG_W    = 12;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 12;
  localparam int CNT_W    = 22;
  localparam int EXPECT_W = COL_W + ROW_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [ROW_W-1:0] ROW_MAX = '1;

  // power-on panel geometry
  localparam int RESET_WIDTH  = 1448;
  localparam int RESET_HEIGHT = 1072;
  localparam int CFG_MAX      = 4095;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    REG_PANEL_WIDTH  = 1'b0,
    REG_PANEL_HEIGHT = 1'b1
  } cfg_reg_t;

  // Everything the back end needs to close out one frame.
  typedef struct packed {
    logic [COL_W-1:0] min_col;
    logic [COL_W-1:0] max_col;
    logic [ROW_W-1:0] min_row;
    logic [ROW_W-1:0] max_row;
    logic [CNT_W-1:0] diff_count;
    logic [CNT_W-1:0] byte_total;
    logic             have_prev;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } frame_sum_t;

endpackage

`default_nettype wire

// ----- hw/rtl/framebuffer_dirty_bounding_box_unit.sv -----
// Top level of the framebuffer dirty bounding box unit.
//
//   channel   direction  handshake              word
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//   in        in         in_valid/in_ready      prev_byte, cur_byte, have_previous, frame_last
//   out       out        out_valid/out_ready    region_x/y/width/height, changed_bytes
//
// One byte pair per cycle while in_ready is high; the front end registers its counters and
// min/max trackers per byte. A frame's summary passes the queue write, then s1, s2, s3
// and the output register, before out_valid rises.
// cfg_ready is always high; a write applies at once, min trackers reseed at the frame clear.
// Reset (rst, synchronous) restores 1448 x 1072 and clears frame state and the queue.
// An output stall holds the back end; in_ready drops only when the four-entry queue fills.
`default_nettype none

module framebuffer_dirty_bounding_box_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [fdbb_pkg::CFG_W-1:0]    cfg_data,
  // byte stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    prev_byte,
  input  logic [7:0]                    cur_byte,
  input  logic                          have_previous,
  input  logic                          frame_last,
  // dirty region
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdbb_pkg::CFG_W-1:0]    region_x,
  output logic [fdbb_pkg::CFG_W-1:0]    region_y,
  output logic [fdbb_pkg::CFG_W-1:0]    region_width,
  output logic [fdbb_pkg::CFG_W-1:0]    region_height,
  output logic [fdbb_pkg::CNT_W-1:0]    changed_bytes
);
  import fdbb_pkg::*;

  logic       take;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  frame_sum_t q_in;
  frame_sum_t q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;

  // accumulate per byte; frame summary pushed on the last word
  fdbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_sel       (cfg_reg_t'(cfg_index)),
    .cfg_data      (cfg_data),
    .take          (take),
    .prev_byte     (prev_byte),
    .cur_byte      (cur_byte),
    .have_previous (have_previous),
    .frame_last    (frame_last),
    .push          (q_push),
    .push_data     (q_in)
  );

  // decouples the byte stream from output stalls
  fdbb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // close-out: geometry check, area compare, final select
  fdbb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .region_x      (region_x),
    .region_y      (region_y),
    .region_width  (region_width),
    .region_height (region_height),
    .changed_bytes (changed_bytes)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/fdbb_front.sv -----
// Front end: geometry registers and per-byte bounding box accumulation.
`default_nettype none

module fdbb_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  fdbb_pkg::cfg_reg_t           cfg_sel,
  input  logic [fdbb_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         take,
  input  logic [7:0]                   prev_byte,
  input  logic [7:0]                   cur_byte,
  input  logic                         have_previous,
  input  logic                         frame_last,
  output logic                         push,
  output fdbb_pkg::frame_sum_t         push_data
);
  import fdbb_pkg::*;

  localparam logic [CFG_W-1:0] W_LIMIT =
    (MAX_WIDTH >= CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] H_LIMIT =
    (MAX_HEIGHT >= CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(MAX_HEIGHT);
  localparam logic [CFG_W-1:0] W_RESET =
    (RESET_WIDTH > MAX_WIDTH) ? W_LIMIT : CFG_W'(RESET_WIDTH);
  localparam logic [CFG_W-1:0] H_RESET =
    (RESET_HEIGHT > MAX_HEIGHT) ? H_LIMIT : CFG_W'(RESET_HEIGHT);

  logic [CFG_W-1:0] panel_width;
  logic [CFG_W-1:0] panel_height;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] min_col;
  logic [COL_W-1:0] max_col;
  logic [ROW_W-1:0] min_row;
  logic [ROW_W-1:0] max_row;
  logic [CNT_W-1:0] diff_count;
  logic [CNT_W-1:0] byte_total;

  logic [COL_W-1:0] row_bytes;
  logic             diff;
  logic             wrap;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] min_col_next;
  logic [COL_W-1:0] max_col_next;
  logic [ROW_W-1:0] min_row_next;
  logic [ROW_W-1:0] max_row_next;
  logic [CNT_W-1:0] diff_count_next;
  logic [CNT_W-1:0] byte_total_next;

  // geometry registers, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= W_RESET;
      panel_height <= H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_PANEL_WIDTH:  panel_width  <= (cfg_data > W_LIMIT) ? W_LIMIT : cfg_data;
        REG_PANEL_HEIGHT: panel_height <= (cfg_data > H_LIMIT) ? H_LIMIT : cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    row_bytes = panel_width[CFG_W-1:3];
    diff      = (prev_byte != cur_byte);
    wrap      = ({1'b0, col} + (COL_W+1)'(1)) >= {1'b0, row_bytes};
    col_next  = wrap ? '0 : col + COL_W'(1);
    row_next  = (wrap && (row != ROW_MAX)) ? row + ROW_W'(1) : row;

    diff_count_next = (diff && (diff_count != CNT_MAX)) ? diff_count + CNT_W'(1)
                                                        : diff_count;
    byte_total_next = (byte_total != CNT_MAX) ? byte_total + CNT_W'(1) : byte_total;
    min_col_next    = (diff && (col < min_col)) ? col : min_col;
    max_col_next    = (diff && (col > max_col)) ? col : max_col;
    min_row_next    = (diff && (row < min_row)) ? row : min_row;
    max_row_next    = (diff && (row > max_row)) ? row : max_row;

    push                 = take && frame_last;
    push_data.min_col    = min_col_next;
    push_data.max_col    = max_col_next;
    push_data.min_row    = min_row_next;
    push_data.max_row    = max_row_next;
    push_data.diff_count = diff_count_next;
    push_data.byte_total = byte_total_next;
    push_data.have_prev  = have_previous;
    push_data.width      = panel_width;
    push_data.height     = panel_height;
  end

  // per-frame state; min trackers start from the geometry seen at clear time
  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      min_col    <= W_RESET[CFG_W-1:3];
      max_col    <= '0;
      min_row    <= H_RESET;
      max_row    <= '0;
      diff_count <= '0;
      byte_total <= '0;
    end else if (take) begin
      if (frame_last) begin
        col        <= '0;
        row        <= '0;
        min_col    <= row_bytes;
        max_col    <= '0;
        min_row    <= panel_height;
        max_row    <= '0;
        diff_count <= '0;
        byte_total <= '0;
      end else begin
        col        <= col_next;
        row        <= row_next;
        min_col    <= min_col_next;
        max_col    <= max_col_next;
        min_row    <= min_row_next;
        max_row    <= max_row_next;
        diff_count <= diff_count_next;
        byte_total <= byte_total_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fdbb_queue.sv -----
// Short queue of frame summaries between front and back ends.
`default_nettype none

module fdbb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fdbb_pkg::frame_sum_t  push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output fdbb_pkg::frame_sum_t  head
);
  import fdbb_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_sum_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full  = (count == COUNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + COUNT_W'(1);
      else if (pop && !push) count <= count - COUNT_W'(1);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/fdbb_back.sv -----
// Back end: frame close-out pipeline (box size, area compare, case select).
`default_nettype none

module fdbb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  fdbb_pkg::frame_sum_t          head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdbb_pkg::CFG_W-1:0]    region_x,
  output logic [fdbb_pkg::CFG_W-1:0]    region_y,
  output logic [fdbb_pkg::CFG_W-1:0]    region_width,
  output logic [fdbb_pkg::CFG_W-1:0]    region_height,
  output logic [fdbb_pkg::CNT_W-1:0]    changed_bytes
);
  import fdbb_pkg::*;

  localparam int DIM_W   = CFG_W + 1;       // box width/height, up to 4096
  localparam int BOX_W   = 2 * DIM_W;
  localparam int PANEL_W = 2 * CFG_W;
  localparam int CMP_W   = BOX_W + 7;       // room for times 100 and times 65

  logic en;

  // stage 1: box extents
  logic             s1_valid;
  frame_sum_t       s1;
  logic [DIM_W-1:0] s1_rw;
  logic [DIM_W-1:0] s1_rh;

  // stage 2: products
  logic                s2_valid;
  frame_sum_t          s2;
  logic [DIM_W-1:0]    s2_rw;
  logic [DIM_W-1:0]    s2_rh;
  logic [BOX_W-1:0]    s2_box;
  logic [PANEL_W-1:0]  s2_panel;
  logic [EXPECT_W-1:0] s2_expect;

  // stage 3: flags
  logic             s3_valid;
  frame_sum_t       s3;
  logic [DIM_W-1:0] s3_rw;
  logic [DIM_W-1:0] s3_rh;
  logic             s3_bad;
  logic             s3_large;

  logic [CMP_W-1:0] box_scaled;
  logic [CMP_W-1:0] panel_scaled;
  logic             bad;

  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_comb begin
    box_scaled   = (CMP_W'(s2_box) << 6) + (CMP_W'(s2_box) << 5) + (CMP_W'(s2_box) << 2);
    panel_scaled = (CMP_W'(s2_panel) << 6) + CMP_W'(s2_panel);
    bad = (s2.width == '0) || (s2.height == '0) || (s2.width[CFG_W-1:3] == '0) ||
          (s2.byte_total == CNT_MAX) || (s2.byte_total != CNT_W'(s2_expect));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= head;
      s1_rw <= {(COL_W+1)'(head.max_col - head.min_col) + (COL_W+1)'(1), 3'b000};
      s1_rh <= DIM_W'(head.max_row - head.min_row) + DIM_W'(1);

      s2        <= s1;
      s2_rw     <= s1_rw;
      s2_rh     <= s1_rh;
      s2_box    <= BOX_W'(s1_rw) * BOX_W'(s1_rh);
      s2_panel  <= PANEL_W'(s1.width) * PANEL_W'(s1.height);
      s2_expect <= EXPECT_W'(s1.width[CFG_W-1:3]) * EXPECT_W'(s1.height);

      s3       <= s2;
      s3_rw    <= s2_rw;
      s3_rh    <= s2_rh;
      s3_bad   <= bad;
      s3_large <= (box_scaled >= panel_scaled);

      if (s3_bad) begin
        region_x      <= '0;
        region_y      <= '0;
        region_width  <= s3.width;
        region_height <= s3.height;
        changed_bytes <= '0;
      end else if (!s3.have_prev) begin
        region_x      <= '0;
        region_y      <= '0;
        region_width  <= s3.width;
        region_height <= s3.height;
        changed_bytes <= s3.byte_total;
      end else if (s3.diff_count == '0) begin
        region_x      <= '0;
        region_y      <= '0;
        region_width  <= '0;
        region_height <= '0;
        changed_bytes <= '0;
      end else if (s3_large) begin
        region_x      <= '0;
        region_y      <= '0;
        region_width  <= s3.width;
        region_height <= s3.height;
        changed_bytes <= s3.diff_count;
      end else begin
        region_x      <= {s3.min_col, 3'b000};
        region_y      <= s3.min_row;
        region_width  <= s3_rw[CFG_W-1:0];
        region_height <= s3_rh[CFG_W-1:0];
        changed_bytes <= s3.diff_count;
      end
    end
  end

`ifndef SYNTH
  a_x_has_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (region_x != '0)) |-> (region_width != '0))
    else $error("offset box with zero width");
  a_y_has_height: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (region_y != '0)) |-> (region_height != '0))
    else $error("offset box with zero height");
`endif

endmodule

`default_nettype wire
